/* rtl/core/ptz_cfd_pkg.sv */
// types, constants and decode functions for the ptz command frame decoder
// no dependencies; used by ptz_cfd_stream_if users and ptz_command_frame_decoder
`default_nettype none

package ptz_cfd_pkg;

	localparam int unsigned FRAME_CHARS = 16;
	localparam int unsigned CNT_W       = 5;

	// header text "A50F"
	localparam logic [0:3][7:0] HDR_TEXT = {8'h41, 8'h35, 8'h30, 8'h46};

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_LEN  = 3'd1;
	localparam logic [2:0] ST_BAD_HDR  = 3'd2;
	localparam logic [2:0] ST_BAD_HEX  = 3'd3;
	localparam logic [2:0] ST_BAD_SUM  = 3'd4;

	// command codes
	localparam logic [4:0] CMD_STOP        = 5'd0;
	localparam logic [4:0] CMD_UP          = 5'd1;
	localparam logic [4:0] CMD_DOWN        = 5'd2;
	localparam logic [4:0] CMD_LEFT        = 5'd3;
	localparam logic [4:0] CMD_RIGHT       = 5'd4;
	localparam logic [4:0] CMD_LEFT_UP     = 5'd5;
	localparam logic [4:0] CMD_LEFT_DOWN   = 5'd6;
	localparam logic [4:0] CMD_RIGHT_UP    = 5'd7;
	localparam logic [4:0] CMD_RIGHT_DOWN  = 5'd8;
	localparam logic [4:0] CMD_ZOOM_IN     = 5'd9;
	localparam logic [4:0] CMD_ZOOM_OUT    = 5'd10;
	localparam logic [4:0] CMD_AUTO        = 5'd11;
	localparam logic [4:0] CMD_IRIS_IN     = 5'd12;
	localparam logic [4:0] CMD_IRIS_OUT    = 5'd13;
	localparam logic [4:0] CMD_FOCUS_IN    = 5'd14;
	localparam logic [4:0] CMD_FOCUS_OUT   = 5'd15;
	localparam logic [4:0] CMD_PRESET_SET  = 5'd16;
	localparam logic [4:0] CMD_PRESET_CALL = 5'd17;
	localparam logic [4:0] CMD_PRESET_DEL  = 5'd18;

	// byte 3 codes
	localparam logic [7:0] B3_PRESET_SET  = 8'h81;
	localparam logic [7:0] B3_PRESET_CALL = 8'h82;
	localparam logic [7:0] B3_PRESET_DEL  = 8'h83;
	localparam logic [3:0] B3_FI_GROUP    = 4'h4;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] command;
		logic [7:0] speed;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	typedef struct packed {
		logic [4:0] command;
		logic [7:0] speed;
	} cls_t;

	// ascii hex digit to nibble, either letter case; non-hex gives nibble 0
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.nib = '0;
		if (c inside {[8'h30:8'h39]}) begin
			r.nib = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			r.nib = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	// command class from byte 3, speed from bytes 4..6
	function automatic cls_t classify(input logic [7:0] b3, input logic [7:0] b4,
			input logic [7:0] b5, input logic [7:0] b6);
		cls_t       r;
		logic [7:0] p45;
		logic       ptz;
		p45       = (b4 == 8'd0) ? b5 : b4;
		ptz       = (b3[7:6] == 2'b00);
		r.command = CMD_STOP;
		r.speed   = '0;
		if (ptz && b3[5]) begin
			r.command = CMD_ZOOM_OUT;
			r.speed   = {4'd0, b6[7:4]};
		end else if (ptz && b3[4]) begin
			r.command = CMD_ZOOM_IN;
			r.speed   = {4'd0, b6[7:4]};
		end else if (ptz && b3[3:0] == 4'hF) begin
			r.command = CMD_AUTO;
			r.speed   = p45;
		end else if (ptz && b3[3]) begin
			if (b3[1]) begin
				r.command = CMD_LEFT_UP;
				r.speed   = p45;
			end else if (b3[0]) begin
				r.command = CMD_RIGHT_UP;
				r.speed   = p45;
			end else begin
				r.command = CMD_UP;
				r.speed   = b5;
			end
		end else if (ptz && b3[2]) begin
			if (b3[1]) begin
				r.command = CMD_LEFT_DOWN;
				r.speed   = p45;
			end else if (b3[0]) begin
				r.command = CMD_RIGHT_DOWN;
				r.speed   = p45;
			end else begin
				r.command = CMD_DOWN;
				r.speed   = b5;
			end
		end else if (ptz && b3[1]) begin
			r.command = CMD_LEFT;
			r.speed   = b4;
		end else if (ptz && b3[0]) begin
			r.command = CMD_RIGHT;
			r.speed   = b4;
		end else if (b3[7:4] == B3_FI_GROUP) begin
			case (b3[3:0])
				4'h4: begin
					r.command = CMD_IRIS_IN;
					r.speed   = b5;
				end
				4'h8: begin
					r.command = CMD_IRIS_OUT;
					r.speed   = b5;
				end
				4'h1: begin
					r.command = CMD_FOCUS_IN;
					r.speed   = b4;
				end
				4'h2: begin
					r.command = CMD_FOCUS_OUT;
					r.speed   = b4;
				end
				default: begin
					r.command = CMD_STOP;
					r.speed   = '0;
				end
			endcase
		end else if (b3 == B3_PRESET_SET) begin
			r.command = CMD_PRESET_SET;
			r.speed   = b5;
		end else if (b3 == B3_PRESET_CALL) begin
			r.command = CMD_PRESET_CALL;
			r.speed   = b5;
		end else if (b3 == B3_PRESET_DEL) begin
			r.command = CMD_PRESET_DEL;
			r.speed   = b5;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/ptz_cfd_stream_if.sv */
// valid/ready stream channel with a typed payload
// payload type is given at instantiation, usually from ptz_cfd_pkg
`default_nettype none

interface ptz_cfd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/ptz_command_frame_decoder.sv */
// ptz command frame decoder, top level
// depends on ptz_cfd_pkg and ptz_cfd_stream_if
`default_nettype none

// Decodes a 16-character ASCII hex PTZ command (header "A50F", 8 bytes,
// byte 7 the 8-bit sum of bytes 0..6) fed one character per request on
// the chars channel; the request with last_char set closes the frame and
// produces one result request on the result channel with status, command
// and speed. Checks run in order: length, header, hex, checksum; any error
// gives command 0 and speed 0. Characters are taken one per clock cycle
// while ready is high, without a gap between frames. Each character passes
// through an input register and then one decode step that updates the frame
// state; the closing character loads the result register from the input
// register once the result register is free, and the result is offered
// from then on until taken. The chars channel holds ready low only while a
// closing character waits in the input register and the result register
// still holds a result that has not been taken.
module ptz_command_frame_decoder (
	input  wire                 clk,
	input  wire                 arst_n,
	ptz_cfd_stream_if.sink      chars,
	ptz_cfd_stream_if.source    result
);

	// input register stage
	logic                   valid_s1;
	ptz_cfd_pkg::char_req_t req_s1;

	// frame state
	logic [ptz_cfd_pkg::CNT_W-1:0] char_count_q;
	logic [3:0]                    high_nibble_q;
	logic [7:0]                    running_sum_q;
	logic                          header_bad_q;
	logic                          hex_bad_q;
	logic                          too_long_q;
	logic [7:0]                    payload_q [4];   // bytes 3..6, no reset

	// result register
	logic                   res_valid_q;
	ptz_cfd_pkg::result_t   res_q;

	logic                   res_free;
	logic                   advance;
	ptz_cfd_pkg::hex_t      hx;
	logic                   in_frame;
	logic [2:0]             byte_idx;
	logic [7:0]             byte_val;
	logic                   header_bad_n;
	logic                   hex_bad_n;
	logic                   too_long_n;
	ptz_cfd_pkg::cls_t      cls;
	ptz_cfd_pkg::result_t   res_n;

	// result slot is free when empty or being drained this cycle
	assign res_free    = !res_valid_q || result.ready;
	// a non-final character never waits; the final one needs the result slot
	assign advance     = valid_s1 && (!req_s1.last_char || res_free);
	assign chars.ready = !valid_s1 || advance;

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	// per-character decode
	always_comb begin
		hx       = ptz_cfd_pkg::hex_decode(req_s1.char_code);
		in_frame = !char_count_q[ptz_cfd_pkg::CNT_W-1];   // fewer than 16 seen
		byte_idx = char_count_q[3:1];
		byte_val = {high_nibble_q, hx.nib};

		header_bad_n = header_bad_q;
		hex_bad_n    = hex_bad_q;
		too_long_n   = too_long_q;
		if (in_frame) begin
			if (char_count_q[3:2] == 2'b00
					&& req_s1.char_code != ptz_cfd_pkg::HDR_TEXT[char_count_q[1:0]]) begin
				header_bad_n = 1'b1;
			end
			if (!hx.ok) begin
				hex_bad_n = 1'b1;
			end
		end else begin
			too_long_n = 1'b1;
		end

		cls = ptz_cfd_pkg::classify(payload_q[0], payload_q[1], payload_q[2], payload_q[3]);

		// status priority: length, header, hex, checksum
		res_n.command = ptz_cfd_pkg::CMD_STOP;
		res_n.speed   = '0;
		if (too_long_n || char_count_q != ptz_cfd_pkg::CNT_W'(ptz_cfd_pkg::FRAME_CHARS - 1)) begin
			res_n.status = ptz_cfd_pkg::ST_BAD_LEN;
		end else if (header_bad_n) begin
			res_n.status = ptz_cfd_pkg::ST_BAD_HDR;
		end else if (hex_bad_n) begin
			res_n.status = ptz_cfd_pkg::ST_BAD_HEX;
		end else if (running_sum_q != byte_val) begin
			// closing character completes byte 7, the checksum
			res_n.status = ptz_cfd_pkg::ST_BAD_SUM;
		end else begin
			res_n.status  = ptz_cfd_pkg::ST_OK;
			res_n.command = cls.command;
			res_n.speed   = cls.speed;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			req_s1 <= chars.payload;
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q  <= '0;
			high_nibble_q <= '0;
			running_sum_q <= '0;
			header_bad_q  <= 1'b0;
			hex_bad_q     <= 1'b0;
			too_long_q    <= 1'b0;
		end else if (advance) begin
			if (req_s1.last_char) begin
				// frame closed, start clean
				char_count_q  <= '0;
				high_nibble_q <= '0;
				running_sum_q <= '0;
				header_bad_q  <= 1'b0;
				hex_bad_q     <= 1'b0;
				too_long_q    <= 1'b0;
			end else begin
				header_bad_q <= header_bad_n;
				hex_bad_q    <= hex_bad_n;
				too_long_q   <= too_long_n;
				if (in_frame) begin
					char_count_q <= char_count_q + 1'b1;
					if (!char_count_q[0]) begin
						high_nibble_q <= hx.nib;
					end else if (byte_idx != 3'd7) begin
						running_sum_q <= running_sum_q + byte_val;
					end
				end
			end
		end
	end

	// payload bytes 3..6
	always_ff @(posedge clk) begin
		if (advance && in_frame && char_count_q[0] && (byte_idx >= 3'd3) && (byte_idx <= 3'd6)) begin
			payload_q[2'(byte_idx - 3'd3)] <= byte_val;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && req_s1.last_char) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_s1.last_char) begin
			res_q <= res_n;
		end
	end

endmodule

`default_nettype wire
